### hw/rtl/szsd_pkg.sv
`timescale 1ns / 1ps
// Package for the short zero-sum detector: group constants, payload and command types,
// and the group arithmetic helpers. No dependencies.
package szsd_pkg;

   localparam int MAX_WEIGHT = 5;
   localparam int MODULUS    = 5;
   localparam int GROUP_SIZE = MODULUS * MODULUS * MODULUS;
   localparam int PLANE_SIZE = MODULUS * MODULUS;
   localparam int COORD_IN_W = 3;
   localparam int COORD_W    = $clog2(MODULUS);
   localparam int GROUP_W    = $clog2(GROUP_SIZE);
   localparam int LAYER_W    = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;

   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [GROUP_W-1:0]    group_index_type;
   typedef logic [GROUP_SIZE-1:0] group_set_type;
   typedef logic [LAYER_W-1:0]    layer_idx_type;

   localparam layer_idx_type LAST_LAYER = LAYER_W'(MAX_WEIGHT - 1);

   typedef struct packed {
      logic [COORD_IN_W-1:0] coord_x;
      logic [COORD_IN_W-1:0] coord_y;
      logic [COORD_IN_W-1:0] coord_z;
      logic                  last_element;
   } req_payload_type;

   typedef struct packed {
      logic zero_sum_found;
      logic sequence_end;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic          load_item;
      logic          check;
      logic          update;
      logic          emit;
      layer_idx_type layer_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic flag;
   } dp_status_type;

   // Reduce a raw 3-bit coordinate modulo MODULUS.
   function automatic coord_type coord_reduce(input logic [COORD_IN_W-1:0] raw);
      logic [COORD_IN_W-1:0] v;
      v = raw;
      for (int i = 0; i < (1 << COORD_IN_W); i++) begin
         if (v >= COORD_IN_W'(MODULUS)) v = v - COORD_IN_W'(MODULUS);
      end
      return COORD_W'(v);
   endfunction

   function automatic coord_type coord_neg(input coord_type c);
      if (c == '0) return '0;
      return COORD_W'(MODULUS) - c;
   endfunction

   // (a - b) mod MODULUS for reduced coordinates.
   function automatic coord_type coord_sub(input coord_type a, input coord_type b);
      logic [COORD_W:0] t;
      t = {1'b0, a} + (COORD_W + 1)'(MODULUS) - {1'b0, b};
      if (a >= b) return a - b;
      return COORD_W'(t);
   endfunction

   function automatic group_index_type elem_index(input coord_type x, input coord_type y,
                                                  input coord_type z);
      return GROUP_W'((int'(x) * MODULUS + int'(y)) * MODULUS + int'(z));
   endfunction

   // Translate a set of group elements by (x, y, z): bit t takes bit t - v.
   // Done one coordinate at a time, each a MODULUS-way select per bit.
   function automatic group_set_type shift_set(input group_set_type s, input coord_type x,
                                               input coord_type y, input coord_type z);
      group_set_type a;
      group_set_type b;
      group_set_type r;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         a[i] = s[(i / MODULUS) * MODULUS
                  + int'(coord_sub(COORD_W'(i % MODULUS), z))];
      end
      for (int i = 0; i < GROUP_SIZE; i++) begin
         b[i] = a[(i / PLANE_SIZE) * PLANE_SIZE
                  + int'(coord_sub(COORD_W'((i / MODULUS) % MODULUS), y)) * MODULUS
                  + (i % MODULUS)];
      end
      for (int i = 0; i < GROUP_SIZE; i++) begin
         r[i] = b[int'(coord_sub(COORD_W'(i / PLANE_SIZE), x)) * PLANE_SIZE
                  + (i % PLANE_SIZE)];
      end
      return r;
   endfunction

endpackage

### hw/rtl/szsd_ctrl.sv
`timescale 1ns / 1ps
// Controller of the short zero-sum detector: sequencing state machine, layer counter
// and result valid. Depends on szsd_pkg.
module szsd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  szsd_pkg::dp_status_type status,
   output szsd_pkg::dp_cmd_type    cmd
);
   import szsd_pkg::*;

   ctrl_state_type state_ff, state_in;
   layer_idx_type  cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free      = !rsp_valid_ff || !rsp_stall;
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.layer_idx = cnt_ff;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = !status.flag;
            if (status.flag || status.hit) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (cnt_ff == LAST_LAYER) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit  = 1'b1;
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.load_item = 1'b1;
                  state_in      = ST_CHECK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Hold while stalled, drop once taken, set on a new result.
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/szsd_datapath.sv
`timescale 1ns / 1ps
// Datapath of the short zero-sum detector: reach layers, sticky flag, element register,
// group shift and zero test, result register. Depends on szsd_pkg.
module szsd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  szsd_pkg::req_payload_type req_data,
   output szsd_pkg::rsp_payload_type rsp_data,
   input  szsd_pkg::dp_cmd_type      cmd,
   output szsd_pkg::dp_status_type   status
);
   import szsd_pkg::*;

   group_set_type   layers_ff [MAX_WEIGHT];
   group_set_type   prev_ff, prev_in;
   logic            flag_ff, flag_in;
   coord_type       x_ff, y_ff, z_ff;
   logic            last_ff;
   rsp_payload_type rsp_data_ff;

   group_set_type   layer_cur;
   group_set_type   layer_new;
   group_index_type target;
   logic            hit;

   always_comb begin
      target = elem_index(coord_neg(x_ff), coord_neg(y_ff), coord_neg(z_ff));
      // Weight zero holds only the identity.
      hit = (target == '0);
      for (int w = 0; w < MAX_WEIGHT - 1; w++) begin
         hit = hit | layers_ff[w][target];
      end
      layer_cur = layers_ff[cmd.layer_idx];
      layer_new = layer_cur | shift_set(prev_ff, x_ff, y_ff, z_ff);
      flag_in   = flag_ff | (cmd.check & hit);
      prev_in   = prev_ff;
      if (cmd.check) begin
         prev_in = group_set_type'(1);
      end else if (cmd.update) begin
         prev_in = layer_cur;
      end
   end

   assign status.hit  = hit;
   assign status.flag = flag_ff;

   always_ff @(posedge clock) begin
      if (reset || (cmd.emit && last_ff)) begin
         flag_ff <= 1'b0;
         for (int w = 0; w < MAX_WEIGHT; w++) layers_ff[w] <= '0;
      end else begin
         flag_ff <= flag_in;
         if (cmd.update) layers_ff[cmd.layer_idx] <= layer_new;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (cmd.load_item) begin
         x_ff    <= coord_reduce(req_data.coord_x);
         y_ff    <= coord_reduce(req_data.coord_y);
         z_ff    <= coord_reduce(req_data.coord_z);
         last_ff <= req_data.last_element;
      end
      if (cmd.emit) begin
         rsp_data_ff.zero_sum_found <= flag_ff;
         rsp_data_ff.sequence_end   <= last_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

### hw/rtl/short_zero_sum_detector_unit.sv
`timescale 1ns / 1ps
// Top level of the short zero-sum detector over (Z_MODULUS)^3.
// Joins szsd_ctrl and szsd_datapath; depends on szsd_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   req     | in        | req_valid/req_stall  | coord_x, coord_y, coord_z, last_element
//   rsp     | out       | rsp_valid/rsp_stall  | zero_sum_found, sequence_end
//
// Steps: after an item's transfer, one zero test, then one update per reach layer
//   through the single shared group shifter, then the result cycle, which loads the
//   result and also takes the next item.
//   Once the flag is up, or the test hits, the layer updates are skipped.
// Reset: synchronous, clears the board, the flag and all handshake state at once.
// Stalls: the result register holds while rsp_stall is high; one more item is
//   accepted and processed behind it, then req_stall rises until the result moves.
module short_zero_sum_detector_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  szsd_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output szsd_pkg::rsp_payload_type rsp_data
);
   import szsd_pkg::*;

   // Command and status between sequencer and datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: accept, test, step the layers, transfer the result.
   szsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Board of reach layers, sticky flag and result payload.
   szsd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

### hw/rtl/szsd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the short zero-sum detector, bound to the top level.
// Depends on szsd_pkg and short_zero_sum_detector_unit.
module szsd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input szsd_pkg::req_payload_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input szsd_pkg::rsp_payload_type rsp_data
);
   import szsd_pkg::*;

   logic [1:0] pending_ff, pending_in;
   logic       sticky_ff, sticky_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};
      sticky_in  = sticky_ff;
      if (rsp_xfer) sticky_in = rsp_data.zero_sum_found && !rsp_data.sequence_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         sticky_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         sticky_ff  <= sticky_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result shown without an outstanding item");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two items outstanding");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sticky_ff |-> rsp_data.zero_sum_found)
      else $error("zero-sum flag dropped within a sequence");

endmodule

bind short_zero_sum_detector_unit szsd_checker u_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for short_zero_sum_detector_unit: directed and random element streams are
// checked against a reach-board predictor kept in this file. Depends on szsd_pkg.
module testbench;
   import szsd_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int CYCLE_LIMIT   = 500000;
   // Settle time after draining: four worst-case items' worth.
   localparam int SETTLE_CYCLES = 4 * (2 + MAX_WEIGHT);
   localparam int MAX_IDLE      = 18;
   localparam int LONG_HOLD     = 300;
   localparam int MAX_PER_AXIS  = MODULUS - 1;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;

   short_zero_sum_detector_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Predictor state: one reachable-sum set per weight 1..MAX_WEIGHT, plus the sticky flag.
   group_set_type   reach_board [MAX_WEIGHT];
   logic            zero_sum_latched;
   rsp_payload_type pending_verdicts [$];

   // Idling knobs, shared by the sender, the receiver and the tests.
   int sender_max_gap     = MAX_IDLE;
   int receiver_max_stall = MAX_IDLE;
   int stall_left         = 0;
   int hold_cycles        = 0;

   int error_count     = 0;
   int elements_sent   = 0;
   int sequences_sent  = 0;
   int results_checked = 0;
   int flagged_results = 0;
   int cycle_count     = 0;

   // Clock: low half, then high half.
   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // ---------------------------------------------------------------------------------
   // Group arithmetic over (Z_MODULUS)^3, element index = (x * M + y) * M + z.
   // ---------------------------------------------------------------------------------
   function automatic int add_elements(input int a, input int b);
      int sx, sy, sz;
      sx = (a / PLANE_SIZE + b / PLANE_SIZE) % MODULUS;
      sy = ((a / MODULUS) % MODULUS + (b / MODULUS) % MODULUS) % MODULUS;
      sz = (a % MODULUS + b % MODULUS) % MODULUS;
      return (sx * MODULUS + sy) * MODULUS + sz;
   endfunction

   function automatic int negate_element(input int a);
      int nx, ny, nz;
      nx = (MODULUS - a / PLANE_SIZE) % MODULUS;
      ny = (MODULUS - (a / MODULUS) % MODULUS) % MODULUS;
      nz = (MODULUS - a % MODULUS) % MODULUS;
      return (nx * MODULUS + ny) * MODULUS + nz;
   endfunction

   task automatic clear_board();
      for (int w = 0; w < MAX_WEIGHT; w++) reach_board[w] = '0;
      zero_sum_latched = 1'b0;
   endtask

   // Advance the board by one element and form the verdict the block must report.
   task automatic advance_board(input req_payload_type item, output rsp_payload_type verdict);
      int            v;
      int            target;
      bit            hit;
      group_set_type lower;
      group_set_type moved;
      // Coordinates of MODULUS or more wrap around.
      v = ((int'(item.coord_x) % MODULUS) * MODULUS + int'(item.coord_y) % MODULUS) * MODULUS
          + int'(item.coord_z) % MODULUS;
      target = negate_element(v);
      // Weight 0 holds only the zero sum, so the zero element always hits.
      hit = (target == 0);
      for (int w = 1; w < MAX_WEIGHT; w++) begin
         if (reach_board[w-1][target]) hit = 1'b1;
      end
      // Once the flag is up the board stays frozen.
      if (!zero_sum_latched) begin
         if (hit) begin
            zero_sum_latched = 1'b1;
         end else begin
            // Walk down so each layer reads the old copy of the layer below it.
            for (int w = MAX_WEIGHT; w >= 1; w--) begin
               if (w == 1) begin
                  lower    = '0;
                  lower[0] = 1'b1;
               end else begin
                  lower = reach_board[w-2];
               end
               moved = '0;
               for (int s = 0; s < GROUP_SIZE; s++) begin
                  if (lower[s]) moved[add_elements(s, v)] = 1'b1;
               end
               reach_board[w-1] = reach_board[w-1] | moved;
            end
         end
      end
      verdict.zero_sum_found = zero_sum_latched;
      verdict.sequence_end   = item.last_element;
      // The verdict is formed first; the last element then clears everything.
      if (item.last_element) clear_board();
   endtask

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   function automatic req_payload_type make_element(input logic [COORD_IN_W-1:0] x,
                                                    input logic [COORD_IN_W-1:0] y,
                                                    input logic [COORD_IN_W-1:0] z,
                                                    input logic last);
      req_payload_type e;
      e.coord_x      = x;
      e.coord_y      = y;
      e.coord_z      = z;
      e.last_element = last;
      return e;
   endfunction

   // Mostly reduced coordinates, now and then a raw code that has to wrap.
   function automatic logic [COORD_IN_W-1:0] draw_coord();
      if ($urandom_range(0, 7) == 0) return COORD_IN_W'($urandom_range(MODULUS, 7));
      return COORD_IN_W'($urandom_range(0, MODULUS - 1));
   endfunction

   task automatic set_idling(input int gap, input int stall);
      sender_max_gap     = gap;
      receiver_max_stall = stall;
   endtask

   // Offer one element after a random gap and hold it until the transfer. Called and
   // left at a falling edge; valid stays high if the next call has no gap.
   task automatic send_element(input req_payload_type item);
      int              gap;
      rsp_payload_type verdict;
      gap = $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_board(item, verdict);
      pending_verdicts.push_back(verdict);
      elements_sent++;
      if (item.last_element) sequences_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result has arrived, then settle.
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_sequence();
      int len;
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         send_element(make_element(draw_coord(), draw_coord(), draw_coord(), i == len - 1));
      end
   endtask

   // Elements on the three axes, one fixed nonzero step per axis and at most
   // MODULUS-1 uses each: no short zero-sum can form, so the board fills deep.
   // An optional random tail element then probes the filled board.
   task automatic send_deep_sequence();
      int                    scale [3];
      int                    used [3];
      int                    len;
      int                    axis;
      bit                    tail;
      logic [COORD_IN_W-1:0] c [3];
      for (int a = 0; a < 3; a++) begin
         scale[a] = $urandom_range(1, MODULUS - 1);
         used[a]  = 0;
      end
      len  = $urandom_range(1, 3 * MAX_PER_AXIS);
      tail = $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
         do axis = $urandom_range(0, 2); while (used[axis] >= MAX_PER_AXIS);
         used[axis]++;
         for (int a = 0; a < 3; a++) begin
            c[a] = ($urandom_range(0, 7) == 0) ? COORD_IN_W'(MODULUS) : '0;
         end
         c[axis] = COORD_IN_W'(scale[axis]);
         if (scale[axis] + MODULUS <= 7 && $urandom_range(0, 3) == 0) begin
            c[axis] = COORD_IN_W'(scale[axis] + MODULUS);
         end
         send_element(make_element(c[0], c[1], c[2], !tail && i == len - 1));
      end
      if (tail) send_element(make_element(draw_coord(), draw_coord(), draw_coord(), 1'b1));
   endtask

   task automatic send_sequence_mix(input int count);
      int start;
      start = elements_sent;
      while (elements_sent - start < count) begin
         if ($urandom_range(0, 9) < 5) send_random_sequence();
         else send_deep_sequence();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------
   task automatic test_directed_cases();
      set_idling(MAX_IDLE, MAX_IDLE);
      // Zero element alone: weight-0 sum hits at once.
      send_element(make_element(3'd0, 3'd0, 3'd0, 1'b1));
      // Opposite pair, all-max coordinates.
      send_element(make_element(3'd4, 3'd4, 3'd4, 1'b0));
      send_element(make_element(3'd1, 3'd1, 3'd1, 1'b1));
      // Raw coordinates wrap: 7 is 2, so 7 + 3 closes a pair.
      send_element(make_element(3'd7, 3'd7, 3'd7, 1'b0));
      send_element(make_element(3'd3, 3'd3, 3'd3, 1'b1));
      // Mixed wrap, then the flag already up for two more elements.
      send_element(make_element(3'd5, 3'd6, 3'd7, 1'b0));
      send_element(make_element(3'd0, 3'd4, 3'd3, 1'b0));
      send_element(make_element(3'd1, 3'd2, 3'd3, 1'b0));
      send_element(make_element(3'd0, 3'd0, 3'd0, 1'b1));
      // Board cleared: the same direction five times hits only at the fifth.
      for (int i = 0; i < MAX_WEIGHT; i++) send_element(make_element(3'd1, 3'd0, 3'd0, 1'b0));
      send_element(make_element(3'd0, 3'd1, 3'd0, 1'b1));
      // Two of each axis, then a diagonal that stays unreachable.
      for (int i = 0; i < 2; i++) begin
         send_element(make_element(3'd1, 3'd0, 3'd0, 1'b0));
         send_element(make_element(3'd0, 3'd1, 3'd0, 1'b0));
         send_element(make_element(3'd0, 3'd0, 3'd1, 1'b0));
      end
      send_element(make_element(3'd1, 3'd1, 3'd1, 1'b1));
      drain_results();
   endtask

   task automatic test_random_sequences(input int count);
      set_idling(MAX_IDLE, MAX_IDLE);
      send_sequence_mix(count);
      drain_results();
   endtask

   // Random end marks: sequences of any length, cut anywhere.
   task automatic test_broken_sequences(input int count);
      set_idling(MAX_IDLE, MAX_IDLE);
      for (int i = 0; i < count; i++) begin
         send_element(make_element(draw_coord(), draw_coord(), draw_coord(),
                                   $urandom_range(0, 4) == 0));
      end
      drain_results();
   endtask

   task automatic test_full_rate(input int count);
      set_idling(0, 0);
      send_sequence_mix(count);
      drain_results();
   endtask

   // Hold the result side off for a long stretch while the sender keeps offering,
   // so the block fills up and stalls its input.
   task automatic test_backpressure(input int count);
      set_idling(0, MAX_IDLE);
      hold_cycles = LONG_HOLD;
      send_sequence_mix(count);
      drain_results();
   endtask

   // Pause the sender until everything is back, then resume.
   task automatic test_drain_pause(input int count);
      set_idling(MAX_IDLE / 2, MAX_IDLE);
      send_sequence_mix(count);
      drain_results();
      send_sequence_mix(count);
      drain_results();
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: the receiver drives stall at the falling edge; after each transfer
   // it draws a fresh stall length. A long hold overrides the per-result stall.
   // ---------------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Checker: compare each transfer at the rising edge with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type expected;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual %b", $time, rsp_data);
         end else begin
            expected = pending_verdicts.pop_front();
            if (rsp_data.zero_sum_found !== expected.zero_sum_found) begin
               error_count++;
               $display("%0t: zero_sum_found mismatch: expected %0b, actual %0b", $time,
                        expected.zero_sum_found, rsp_data.zero_sum_found);
            end
            if (rsp_data.sequence_end !== expected.sequence_end) begin
               error_count++;
               $display("%0t: sequence_end mismatch: expected %0b, actual %0b", $time,
                        expected.sequence_end, rsp_data.sequence_end);
            end
            results_checked++;
            if (expected.zero_sum_found) flagged_results++;
         end
         stall_left = $urandom_range(0, receiver_max_stall);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // Main sequence: reset once, then each test in turn.
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      clear_board();
      // Hold reset, then release it at a falling edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_sequences(1050);
      test_broken_sequences(200);
      test_full_rate(250);
      test_backpressure(40);
      test_drain_pause(30);

      $display("summary: %0d elements in %0d closed sequences, %0d results checked, %0d flagged",
               elements_sent, sequences_sent, results_checked, flagged_results);
      $display("summary: directed cases, random and deep sequences, cut sequences, full rate,");
      $display("summary: long result hold-off and sender pause were exercised");
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
